// ===== design/stt_pkg.sv =====
// Shared types and codes for the sorted timer table.
package stt_pkg;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_ADJUST = 2'd2,
		CMD_TICK   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_STATUS = 2'd0,
		KIND_FIRED  = 2'd1,
		KIND_EMPTY  = 2'd2
	} kind_t;

	localparam int unsigned SLOT_FIELD_BITS = 4;
	localparam int unsigned PERIOD_BITS     = 16;
	localparam int unsigned IN_TDATA_BITS   = 104;
	localparam int unsigned OUT_TDATA_BITS  = 8;

endpackage

// ===== design/sorted_timer_table_top.sv =====
// Top level of the sorted timer table: command decode, ordered list and sequencer.
//
// The block keeps SLOTS timer slots and a list of the armed slots sorted by
// expiry (ties in arming order). Commands arrive as words on the s_axis
// channel, with the command code on s_axis_tuser. Results leave as words on
// the m_axis channel, with the result kind on m_axis_tuser.
// Add, delete and adjust give one status word. A tick gives one word per
// fired slot, in list order, or a single "nothing fired" word. tlast marks
// the final word belonging to one command.
// All list work is done by one sequencer that walks the order list one entry
// per cycle with a single shared time comparator and a single saturating adder.
// An add searches the list for its place and shifts the tail up; a delete finds
// the slot and closes the gap; an adjust does a delete and then an add. A tick
// removes each fired slot as a delete does and re-inserts a re-armed one as an add does.
// The input is not ready while a command is being worked on. The result
// register holds its word while the receiver stalls, and the sequencer waits
// for it to drain before producing the next word, so a stall adds directly
// to the time of the command.
// Reset clears the armed flags and the list count; expiry, period and list
// storage need no clearing since only armed entries are ever read.
module sorted_timer_table_top #(
	parameter int unsigned SLOTS     = 16,
	parameter int unsigned TIME_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// slot[3:0], expiry_time[35:4], period[51:36], delay[67:52],
	// now_time[99:68], zero fill [103:100]
	input  logic [stt_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
	// cmd[1:0]
	input  stt_pkg::cmd_t                       s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// fired_slot[3:0], ok[4], rearmed[5], zero fill [7:6]
	output logic [stt_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
	// kind[1:0]
	output stt_pkg::kind_t                      m_axis_tuser,
	output logic                                m_axis_tlast
);
	import stt_pkg::*;

	localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned CW = $clog2(SLOTS + 1);
	localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

	typedef enum logic [3:0] {
		ST_IDLE, ST_DECODE, ST_RM_FIND, ST_RM_SHIFT, ST_INS_FIND, ST_INS_SHIFT,
		ST_TICK_HEAD, ST_TICK_CHK, ST_EMIT
	} state_t;

	state_t                 state_q;
	logic [TIME_BITS-1:0]   expiry_q [SLOTS];
	logic [PERIOD_BITS-1:0] period_q [SLOTS];
	logic [IW-1:0]          order_q  [SLOTS];
	logic [SLOTS-1:0]       active_q;
	logic [CW-1:0]          count_q;

	cmd_t                   cmd_q;
	logic [SLOT_FIELD_BITS-1:0] slot_in_q;
	logic [TIME_BITS-1:0]   exp_in_q;
	logic [PERIOD_BITS-1:0] per_in_q;
	logic [PERIOD_BITS-1:0] dly_q;
	logic [TIME_BITS-1:0]   now_q;
	logic [IW-1:0]          s_q;
	logic [CW-1:0]          idx_q;
	logic                   ok_q;
	logic                   fired_any_q;
	logic [SLOTS-1:0]       fired_q;
	logic                   rearm_q;
	logic [TIME_BITS-1:0]   key_q;

	logic [OUT_TDATA_BITS-1:0] out_data_q;
	kind_t                  out_kind_q;
	logic                   out_last_q;
	logic                   out_valid_q;
	kind_t                  res_kind_q;

	// Shared saturating adder and comparator.
	logic [PERIOD_BITS-1:0] add_b;
	logic [TIME_BITS:0]     add_sum;
	logic [TIME_BITS-1:0]   sat_sum;
	logic [IW-1:0]          ent;
	logic                   idx_in;
	logic                   key_le;
	logic                   head_due;
	logic                   slot_valid;

	// Outside decode the adder re-arms the list head, which is the slot about to fire.
	assign add_b   = (state_q == ST_DECODE) ? dly_q : period_q[ent];
	assign add_sum = {1'b0, now_q} + {{(TIME_BITS+1-PERIOD_BITS){1'b0}}, add_b};
	assign sat_sum = add_sum[TIME_BITS] ? TMAX : add_sum[TIME_BITS-1:0];
	assign idx_in  = idx_q < count_q;
	assign ent     = order_q[idx_q[IW-1:0]];
	assign key_le  = expiry_q[ent] <= ((state_q == ST_INS_FIND) ? key_q : now_q);
	// A slot already fired in this tick sits behind every slot still due.
	assign head_due = idx_in && key_le && !fired_q[ent];
	assign slot_valid = {{(32-SLOT_FIELD_BITS){1'b0}}, slot_in_q} < SLOTS;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			active_q    <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			fired_any_q <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						cmd_q     <= s_axis_tuser;
						slot_in_q <= s_axis_tdata[3:0];
						exp_in_q  <= TIME_BITS'(s_axis_tdata[35:4]);
						per_in_q  <= s_axis_tdata[51:36];
						dly_q     <= s_axis_tdata[67:52];
						now_q     <= TIME_BITS'(s_axis_tdata[99:68]);
						s_q       <= IW'(s_axis_tdata[3:0]);
						fired_any_q <= 1'b0;
						fired_q   <= '0;
						state_q   <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					idx_q <= '0;
					res_kind_q <= KIND_STATUS;
					rearm_q <= 1'b0;
					case (cmd_q)
						CMD_TICK: begin
							state_q <= ST_TICK_HEAD;
						end
						CMD_ADD: begin
							ok_q <= slot_valid && !active_q[s_q];
							if (slot_valid && !active_q[s_q]) begin
								expiry_q[s_q] <= exp_in_q;
								period_q[s_q] <= per_in_q;
								active_q[s_q] <= 1'b1;
								key_q   <= exp_in_q;
								state_q <= ST_INS_FIND;
							end else begin
								state_q <= ST_EMIT;
							end
						end
						default: begin
							ok_q <= slot_valid && active_q[s_q];
							key_q <= sat_sum;
							if (slot_valid && active_q[s_q]) begin
								state_q <= ST_RM_FIND;
							end else begin
								state_q <= ST_EMIT;
							end
						end
					endcase
				end
				ST_RM_FIND: begin
					if (ent == s_q) begin
						state_q <= ST_RM_SHIFT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_RM_SHIFT: begin
					if (idx_q + 1'b1 < count_q) begin
						order_q[idx_q[IW-1:0]] <= order_q[IW'(idx_q + 1'b1)];
						idx_q <= idx_q + 1'b1;
					end else begin
						count_q <= count_q - 1'b1;
						idx_q   <= '0;
						if (cmd_q == CMD_DELETE) begin
							active_q[s_q] <= 1'b0;
							state_q <= ST_EMIT;
						end else if (cmd_q == CMD_TICK && !rearm_q) begin
							active_q[s_q] <= 1'b0;
							state_q <= ST_EMIT;
						end else begin
							expiry_q[s_q] <= key_q;
							state_q <= ST_INS_FIND;
						end
					end
				end
				ST_INS_FIND: begin
					if (idx_in && key_le) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						key_q <= TIME_BITS'(idx_q);
						idx_q <= count_q;
						state_q <= ST_INS_SHIFT;
					end
				end
				ST_INS_SHIFT: begin
					// key_q holds the insert position here.
					if (idx_q > key_q[CW-1:0]) begin
						order_q[idx_q[IW-1:0]] <= order_q[IW'(idx_q - 1'b1)];
						idx_q <= idx_q - 1'b1;
					end else begin
						order_q[idx_q[IW-1:0]] <= s_q;
						count_q <= count_q + 1'b1;
						idx_q   <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_TICK_HEAD: begin
					idx_q <= '0;
					state_q <= ST_TICK_CHK;
				end
				ST_TICK_CHK: begin
					// The slots still due always lead the list, so the head decides.
					if (!out_valid_q) begin
						if (head_due) begin
							s_q          <= ent;
							rearm_q      <= period_q[ent] != '0;
							key_q        <= sat_sum;
							res_kind_q   <= KIND_FIRED;
							ok_q         <= 1'b1;
							fired_any_q  <= 1'b1;
							fired_q[ent] <= 1'b1;
							state_q      <= ST_RM_FIND;
						end else begin
							if (!fired_any_q) begin
								out_data_q  <= OUT_TDATA_BITS'({1'b0, 1'b1,
									{SLOT_FIELD_BITS{1'b0}}});
								out_kind_q  <= KIND_EMPTY;
								out_last_q  <= 1'b1;
								out_valid_q <= 1'b1;
							end
							state_q <= ST_IDLE;
						end
					end
				end
				ST_EMIT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						out_data_q  <= OUT_TDATA_BITS'({rearm_q, ok_q,
							(res_kind_q == KIND_FIRED) ? SLOT_FIELD_BITS'(s_q) : slot_in_q});
						out_kind_q  <= res_kind_q;
						if (cmd_q == CMD_TICK) begin
							// Last only if the list head is not due as well; idx_q is zero here.
							out_last_q <= !head_due;
							state_q <= ST_TICK_HEAD;
						end else begin
							out_last_q <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	property p_ready_only_idle;
		@(posedge clk) disable iff (!arst_n) s_axis_tready |-> (state_q == ST_IDLE);
	endproperty
	assert property (p_ready_only_idle) else $error("ready outside idle");

	property p_count_bound;
		@(posedge clk) disable iff (!arst_n) count_q <= CW'(SLOTS);
	endproperty
	assert property (p_count_bound) else $error("list count overflow");

	property p_count_matches;
		@(posedge clk) disable iff (!arst_n)
			(state_q == ST_IDLE) |-> ($countones(active_q) == count_q);
	endproperty
	assert property (p_count_matches) else $error("count differs from armed slots");

	property p_out_hold;
		@(posedge clk) disable iff (!arst_n)
			(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid &&
				$stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast));
	endproperty
	assert property (p_out_hold) else $error("result word changed while stalled");

endmodule

// ===== bench/sorted_timer_table_top_tb.sv =====
// Self-checking testbench for the sorted timer table: directed table, then random commands.
module sorted_timer_table_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import stt_pkg::*;

	localparam int NSLOT = 16;
	localparam logic [31:0] TIME_TOP = 32'hFFFF_FFFF;

	// One command word as the block sees it.
	typedef struct packed {
		logic [31:0] now_time;
		logic [15:0] delay;
		logic [15:0] period;
		logic [31:0] expiry_time;
		logic [3:0]  slot;
		cmd_t        cmd;
	} cmd_word_t;

	// One result word, fields from last down to kind.
	typedef struct packed {
		logic       last;
		logic       rearmed;
		logic       ok;
		logic [3:0] fired_slot;
		kind_t      kind;
	} result_t;

	// A row of the directed table; chk marks a result typed in by hand.
	typedef struct {
		cmd_word_t w;
		bit        chk;
		result_t   r;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_BITS-1:0] s_axis_tdata = '0;
	cmd_t s_axis_tuser = CMD_ADD;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
	kind_t m_axis_tuser;
	logic m_axis_tlast;

	sorted_timer_table_top uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #10 clk = ~clk;

	// Predictor state: a shadow copy of the timer table.
	logic [31:0] exp_time [NSLOT];
	logic [15:0] rearm_ival [NSLOT];
	bit          armed [NSLOT];
	int          fire_order [$];

	result_t pending_results [$];
	int      mismatches = 0;
	bit      quiet = 1'b0;      // sender forbidden from idling
	bit      hold_off = 1'b0;   // receiver holds off for a long stretch
	row_t    dir_rows [$];
	int      dir_idx = 0;

	function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? TIME_TOP : s[31:0];
	endfunction

	function automatic void unlink(int s);
		foreach (fire_order[i])
			if (fire_order[i] == s) begin
				fire_order.delete(i);
				return;
			end
	endfunction

	// Sorted insert, after every slot with an equal expiry.
	function automatic void link(int s);
		int pos;
		pos = 0;
		while (pos < fire_order.size() && exp_time[fire_order[pos]] <= exp_time[s])
			pos++;
		fire_order.insert(pos, s);
	endfunction

	function automatic result_t mk(kind_t k, int sl, bit ok, bit re, bit last);
		result_t r;
		r.kind = k;
		r.fired_slot = sl[3:0];
		r.ok = ok;
		r.rearmed = re;
		r.last = last;
		return r;
	endfunction

	// Applies one command to the shadow table and queues its results.
	function automatic void predict_timer_cmd(cmd_word_t w);
		int n, s, f;
		int due [$];
		bit ok, re;
		s = w.slot;
		if (w.cmd == CMD_TICK) begin
			n = 0;
			while (n < fire_order.size() && exp_time[fire_order[n]] <= w.now_time) begin
				due.push_back(fire_order[n]);
				n++;
			end
			if (n == 0) begin
				pending_results.push_back(mk(KIND_EMPTY, 0, 1, 0, 1));
				return;
			end
			foreach (due[i]) begin
				f = due[i];
				re = rearm_ival[f] != 0;
				unlink(f);
				if (re) begin
					exp_time[f] = sat_sum(w.now_time, {16'd0, rearm_ival[f]});
					link(f);
				end else begin
					armed[f] = 1'b0;
				end
				pending_results.push_back(mk(KIND_FIRED, f, 1, re, i == n - 1));
			end
		end else if (w.cmd == CMD_ADD) begin
			ok = !armed[s];
			if (ok) begin
				exp_time[s] = w.expiry_time;
				rearm_ival[s] = w.period;
				armed[s] = 1'b1;
				link(s);
			end
			pending_results.push_back(mk(KIND_STATUS, s, ok, 0, 1));
		end else begin
			ok = armed[s];
			if (ok) begin
				unlink(s);
				if (w.cmd == CMD_DELETE) begin
					armed[s] = 1'b0;
				end else begin
					exp_time[s] = sat_sum(w.now_time, {16'd0, w.delay});
					link(s);
				end
			end
			pending_results.push_back(mk(KIND_STATUS, s, ok, 0, 1));
		end
	endfunction

	function automatic cmd_word_t cw(cmd_t c, int sl, logic [31:0] ex, logic [15:0] per,
			logic [15:0] dl, logic [31:0] nw);
		cmd_word_t w;
		w.cmd = c;
		w.slot = sl[3:0];
		w.expiry_time = ex;
		w.period = per;
		w.delay = dl;
		w.now_time = nw;
		return w;
	endfunction

	function automatic void add_row(cmd_word_t w, bit chk, result_t r);
		row_t rw;
		rw.w = w;
		rw.chk = chk;
		rw.r = r;
		dir_rows.push_back(rw);
	endfunction

	// Random command, biased toward sequences that keep several slots armed.
	function automatic cmd_word_t rand_cmd(logic [31:0] clock_now);
		cmd_word_t w;
		int p;
		w = cw(CMD_TICK, $urandom_range(0, 15), $urandom, 16'($urandom), 16'($urandom),
			$urandom);
		p = $urandom_range(0, 99);
		if (p < 35) begin
			w.cmd = CMD_ADD;
			if ($urandom_range(0, 9) < 8)
				w.expiry_time = clock_now + $urandom_range(0, 300);
			if ($urandom_range(0, 3) == 0)
				w.period = 16'd0;
			else if ($urandom_range(0, 3) != 0)
				w.period = 16'($urandom_range(1, 200));
		end else if (p < 50) begin
			w.cmd = CMD_DELETE;
		end else if (p < 65) begin
			w.cmd = CMD_ADJUST;
			if ($urandom_range(0, 3) != 0) begin
				w.now_time = clock_now;
				w.delay = 16'($urandom_range(0, 300));
			end
		end else begin
			w.cmd = CMD_TICK;
			if ($urandom_range(0, 19) != 0)
				w.now_time = clock_now + $urandom_range(0, 150);
		end
		return w;
	endfunction

	// Sender: drives a word at the falling edge, waits for the handshake at the rising edge.
	task automatic send_word(cmd_word_t w);
		while (!quiet && $urandom_range(0, 99) < 27) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tdata <= {4'b0000, w.now_time, w.delay, w.period, w.expiry_time, w.slot};
		s_axis_tuser <= w.cmd;
		s_axis_tvalid <= 1'b1;
		predict_timer_cmd(w);
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic drain_results();
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// Receiver: random stalls, plus one long hold-off.
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_axis_tready <= 1'b0;
				for (hold = 0; hold < 400; hold++)
					@(negedge clk);
				hold_off = 1'b0;
			end
			m_axis_tready <= quiet || ($urandom_range(0, 99) >= 27);
		end
	end

	// Monitor: compares every accepted result with the oldest expectation.
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.last = m_axis_tlast;
			got.rearmed = m_axis_tdata[5];
			got.ok = m_axis_tdata[4];
			got.fired_slot = m_axis_tdata[3:0];
			got.kind = m_axis_tuser;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %p", got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	initial begin
		int k;
		logic [31:0] clock_now;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table: error codes, extremes, ties, saturation, rearm within a tick.
		add_row(cw(CMD_TICK, 0, 0, 0, 0, TIME_TOP), 1, mk(KIND_EMPTY, 0, 1, 0, 1));
		add_row(cw(CMD_DELETE, 3, 0, 0, 0, 0), 1, mk(KIND_STATUS, 3, 0, 0, 1));
		add_row(cw(CMD_ADJUST, 15, 0, 0, 16'hFFFF, 0), 1, mk(KIND_STATUS, 15, 0, 0, 1));
		add_row(cw(CMD_ADD, 0, 100, 0, 0, 0), 1, mk(KIND_STATUS, 0, 1, 0, 1));
		add_row(cw(CMD_ADD, 0, 5, 7, 0, 0), 1, mk(KIND_STATUS, 0, 0, 0, 1));
		add_row(cw(CMD_ADD, 15, 100, 16'hFFFF, 0, 0), 1, mk(KIND_STATUS, 15, 1, 0, 1));
		add_row(cw(CMD_ADD, 7, 50, 1, 0, 0), 1, mk(KIND_STATUS, 7, 1, 0, 1));
		add_row(cw(CMD_ADD, 9, TIME_TOP, 0, 0, 0), 1, mk(KIND_STATUS, 9, 1, 0, 1));
		add_row(cw(CMD_ADD, 4, 0, 0, 0, 0), 1, mk(KIND_STATUS, 4, 1, 0, 1));
		add_row(cw(CMD_TICK, 0, 0, 0, 0, 99), 0, '0);
		add_row(cw(CMD_TICK, 0, 0, 0, 0, 200), 0, '0);
		add_row(cw(CMD_ADJUST, 7, 0, 0, 16'hFFFF, 32'hFFFF_FFF0), 1,
			mk(KIND_STATUS, 7, 1, 0, 1));
		add_row(cw(CMD_TICK, 0, 0, 0, 0, 32'hFFFF_FF00), 0, '0);
		add_row(cw(CMD_TICK, 0, 0, 0, 0, TIME_TOP), 0, '0);
		add_row(cw(CMD_DELETE, 15, 0, 0, 0, 0), 1, mk(KIND_STATUS, 15, 1, 0, 1));
		add_row(cw(CMD_DELETE, 7, 0, 0, 0, 0), 1, mk(KIND_STATUS, 7, 1, 0, 1));
		add_row(cw(CMD_DELETE, 7, 0, 0, 0, 0), 1, mk(KIND_STATUS, 7, 0, 0, 1));
		add_row(cw(CMD_TICK, 0, 0, 0, 0, 32'h7FFF_FFFF), 0, '0);
		for (k = 0; k < NSLOT; k++)
			add_row(cw(CMD_ADD, k, 32'h10, k[0] ? 16'd0 : 16'd3, 0, 0), 0, '0);
		add_row(cw(CMD_TICK, 0, 0, 0, 0, 32'h20), 0, '0);

		foreach (dir_rows[i]) begin
			send_word(dir_rows[i].w);
			// Hand-typed rows also get checked against the predictor's view.
			if (dir_rows[i].chk && pending_results[$] !== dir_rows[i].r) begin
				mismatches++;
				if (mismatches <= 10)
					$display("row %0d: table expects %p, predictor %p",
						i, dir_rows[i].r, pending_results[$]);
			end
		end

		// Random part. Around item 150 the receiver holds off while the sender keeps going.
		clock_now = 32'h40;
		for (k = 0; k < 440; k++) begin
			if (k == 150)
				hold_off = 1'b1;
			quiet = (k >= 300 && k < 360);
			send_word(rand_cmd(clock_now));
			clock_now += $urandom_range(0, 40);
		end
		s_axis_tvalid <= 1'b0;
		quiet = 1'b0;
		drain_results();
		repeat (200) @(negedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#50ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
design/stt_pkg.sv
design/sorted_timer_table_top.sv
bench/sorted_timer_table_top_tb.sv
